// ===== rtl/core/gray_world_white_balance_defines.svh =====
// ----------------------------------------------------------------------------
// gray world white balance assertion macros
// shared concurrent assertion wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef GRAY_WORLD_WHITE_BALANCE_DEFINES_SVH
`define GRAY_WORLD_WHITE_BALANCE_DEFINES_SVH

// plain property under clock and active-low reset
`define GWWB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("gwwb assertion failed");

// antecedent in one cycle implies consequent in the next
`define GWWB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gwwb assertion failed");

`endif

// ===== rtl/core/gwwb_pkg.sv =====
// ----------------------------------------------------------------------------
// gwwb_pkg
// shared types and constants of the gray world white balance block
// ----------------------------------------------------------------------------
`default_nettype none
package gwwb_pkg;
  localparam int unsigned MaxPixelsDef = 262144;
  localparam int unsigned ChN          = 3;
  localparam int unsigned PixW         = 8;
  localparam int unsigned QuotW        = 8;
  localparam logic [7:0]  TargetReset  = 8'd128;
  localparam logic [7:0]  SatLevel     = 8'd255;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/gwwb_ram.sv =====
// ----------------------------------------------------------------------------
// gwwb_ram
// generic simple dual-port synchronous ram (one write port, one read port) with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module gwwb_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 262144,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/core/gwwb_div.sv =====
// ----------------------------------------------------------------------------
// gwwb_div
// iterative restoring divider, one quotient bit per cycle, 8-bit quotient
// ----------------------------------------------------------------------------
`default_nettype none
module gwwb_div #(
  parameter int unsigned NumW = 27,
  parameter int unsigned DenW = 19
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire gwwb_pkg::div_ctrl_t        ctrl_i,
  input  wire logic [NumW-1:0]            num_i,
  input  wire logic [DenW-1:0]            den_i,
  output gwwb_pkg::div_stat_t             stat_o,
  output logic [gwwb_pkg::QuotW-1:0]      quot_o
);
  import gwwb_pkg::*;

  localparam int unsigned ShW = DenW + QuotW - 1;
  localparam int unsigned CW  = (NumW > ShW) ? NumW : ShW;
  localparam int unsigned StW = $clog2(QuotW);

  logic [NumW-1:0]  rem_q;
  logic [ShW-1:0]   dsh_q;
  logic [QuotW-1:0] quot_q;
  logic [StW-1:0]   step_q;
  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    rem_x;
  logic [CW-1:0]    dsh_x;
  logic             ge;

  assign rem_x = CW'(rem_q);
  assign dsh_x = CW'(dsh_q);
  assign ge    = (rem_x >= dsh_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      dsh_q  <= '0;
      quot_q <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        rem_q  <= num_i;
        dsh_q  <= {den_i, {(QuotW-1){1'b0}}};
        quot_q <= '0;
        step_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (ge) begin
          rem_q <= NumW'(rem_x - dsh_x);
        end
        quot_q <= {quot_q[QuotW-2:0], ge};
        dsh_q  <= dsh_q >> 1;
        step_q <= step_q + 1'b1;
        if (step_q == StW'(QuotW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;
endmodule
`default_nettype wire

// ===== rtl/core/gray_world_white_balance.sv =====
// ----------------------------------------------------------------------------
// gray_world_white_balance
// gray-world white balance over one stored frame of bgr pixels
// ----------------------------------------------------------------------------
// Loads (tuser 0) store a pixel in the frame ram while it has room; a load with
// tlast closes the frame, and the block stays busy while the three 8-step
// dividers form the channel averages. An emit (tuser 1) works on all three
// channels side by side: the ram read at acceptance, one multiply by
// target_level, a divider start, 8 divider steps, a capture, then the move
// into the output register, where it waits while the previous result is not
// yet taken. An emit with no pixel to return is consumed with no output. Input
// is taken one item at a time.
`default_nettype none
module gray_world_white_balance #(
  parameter int unsigned MAX_PIXELS = gwwb_pkg::MaxPixelsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,     // target_level
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,    // blue_in, green_in, red_in
  input  wire logic        s_axis_tuser,    // cmd
  input  wire logic        s_axis_tlast,    // frame_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,    // blue_out, green_out, red_out
  output logic             m_axis_tlast     // last_out
);
  import gwwb_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned AddrW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned SumW = CntW + PixW;
  localparam int unsigned PrdW = 2 * PixW;
  localparam int unsigned NumW = (SumW > PrdW) ? SumW : PrdW;
  localparam int unsigned DenW = (CntW > PixW) ? CntW : PixW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_AVG, ST_AVG_WAIT, ST_PROD, ST_DIV, ST_DIV_WAIT, ST_OUT
  } state_e;

  state_e            state_q;
  logic [7:0]        target_q;
  logic [SumW-1:0]   sum_q   [ChN];
  logic [PixW-1:0]   avg_q   [ChN];
  logic [PrdW-1:0]   prod_q  [ChN];
  logic [ChN-1:0]    sat_q;
  logic [ChN-1:0]    zero_q;
  logic [PixW-1:0]   res_q   [ChN];
  logic              res_last_q;
  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   rp_q;
  logic              ready_q;

  logic              s_acc;
  logic              load_acc;
  logic              emit_acc;
  logic [CntW-1:0]   count_b;
  logic              room;
  logic              can_emit;
  pixel_t            pix_in;
  pixel_t            pix_rd;
  logic [PixW-1:0]   pch     [ChN];
  logic [PixW-1:0]   ich     [ChN];
  div_ctrl_t         dctrl;
  div_stat_t         dstat   [ChN];
  logic [QuotW-1:0]  quot    [ChN];
  logic [NumW-1:0]   dnum    [ChN];
  logic [DenW-1:0]   dden    [ChN];
  logic              out_free;

  assign pix_in   = pixel_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign load_acc = s_acc && !s_axis_tuser;
  assign emit_acc = s_acc && s_axis_tuser;
  assign count_b  = ready_q ? '0 : count_q;
  assign room     = (count_b < CntW'(MAX_PIXELS));
  assign can_emit = ready_q && (rp_q < count_q);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign ich[0] = pix_in.blue;
  assign ich[1] = pix_in.green;
  assign ich[2] = pix_in.red;
  assign pch[0] = pix_rd.blue;
  assign pch[1] = pix_rd.green;
  assign pch[2] = pix_rd.red;

  gwwb_ram #(
    .Width(3 * PixW),
    .Depth(MAX_PIXELS),
    .AddrW(AddrW)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (load_acc && room),
    .waddr_i(count_b[AddrW-1:0]),
    .wdata_i(s_axis_tdata),
    .raddr_i(rp_q[AddrW-1:0]),
    .rdata_o(pix_rd)
  );

  assign dctrl.start = (state_q == ST_AVG) || (state_q == ST_DIV);

  for (genvar c = 0; c < ChN; c++) begin : g_lane
    assign dnum[c] = (state_q == ST_AVG) ? NumW'(sum_q[c]) : NumW'(prod_q[c]);
    assign dden[c] = (state_q == ST_AVG) ? DenW'(count_q) : DenW'(avg_q[c]);
    gwwb_div #(
      .NumW(NumW),
      .DenW(DenW)
    ) u_div (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(dctrl),
      .num_i (dnum[c]),
      .den_i (dden[c]),
      .stat_o(dstat[c]),
      .quot_o(quot[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      target_q      <= TargetReset;
      count_q       <= '0;
      rp_q          <= '0;
      ready_q       <= 1'b0;
      res_last_q    <= 1'b0;
      sat_q         <= '0;
      zero_q        <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tlast  <= 1'b0;
      for (int c = 0; c < ChN; c++) begin
        sum_q[c]  <= '0;
        avg_q[c]  <= '0;
        prod_q[c] <= '0;
        res_q[c]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        target_q <= cfg_wdata_i;
      end
      if (m_axis_tvalid && m_axis_tready && (state_q != ST_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (load_acc) begin
            for (int c = 0; c < ChN; c++) begin
              sum_q[c] <= (ready_q ? '0 : sum_q[c]) + (room ? SumW'(ich[c]) : '0);
            end
            count_q <= room ? count_b + 1'b1 : count_b;
            if (ready_q) begin
              rp_q    <= '0;
              ready_q <= 1'b0;
            end
            if (s_axis_tlast) begin
              state_q <= ST_AVG;
            end
          end else if (emit_acc && can_emit) begin
            res_last_q <= (rp_q + 1'b1 == count_q);
            rp_q       <= rp_q + 1'b1;
            state_q    <= ST_PROD;
          end
        end
        ST_AVG: begin
          state_q <= ST_AVG_WAIT;
        end
        ST_AVG_WAIT: begin
          if (dstat[0].done) begin
            for (int c = 0; c < ChN; c++) begin
              avg_q[c] <= (count_q == '0) ? '0 : quot[c];
            end
            rp_q    <= '0;
            ready_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_PROD: begin
          for (int c = 0; c < ChN; c++) begin
            prod_q[c] <= target_q * pch[c];
          end
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          for (int c = 0; c < ChN; c++) begin
            zero_q[c] <= (avg_q[c] == '0);
            sat_q[c]  <= (prod_q[c] >= {avg_q[c], {PixW{1'b0}}});
          end
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (dstat[0].done) begin
            for (int c = 0; c < ChN; c++) begin
              res_q[c] <= zero_q[c] ? '0 : (sat_q[c] ? SatLevel : quot[c]);
            end
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {res_q[2], res_q[1], res_q[0]};
            m_axis_tlast  <= res_last_q;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  logic unused_busy;
  assign unused_busy = dstat[0].busy ^ dstat[1].busy ^ dstat[2].busy
                     ^ dstat[1].done ^ dstat[2].done;
endmodule
`default_nettype wire

// ===== rtl/core/gwwb_checker.sv =====
// ----------------------------------------------------------------------------
// gwwb_checker
// port-level assertions for the gray world white balance block
// ----------------------------------------------------------------------------
`default_nettype none
`include "gray_world_white_balance_defines.svh"
module gwwb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tuser,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);
  logic load_acc;
  assign load_acc = s_axis_tvalid && s_axis_tready && !s_axis_tuser;

  // stalled result holds
  `GWWB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  // closing a frame busies the block for the averages
  `GWWB_ASSERT_NEXT(a_close_busy, clk_i, rst_ni, load_acc && s_axis_tlast, !s_axis_tready)
  // a plain load leaves the block ready again in the next cycle
  `GWWB_ASSERT_NEXT(a_load_fast, clk_i, rst_ni, load_acc && !s_axis_tlast, s_axis_tready)
endmodule

bind gray_world_white_balance gwwb_checker u_gwwb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
`default_nettype wire
